// File: rtl/core/circle_raster_generator_core_assert.svh
// Assertion macros for the circle rasterizer RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef CIRCLE_RASTER_GENERATOR_CORE_ASSERT_SVH
`define CIRCLE_RASTER_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define CRG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define CRG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/crg_pkg.sv
// Package for the circle rasterizer: field widths, codes, the job type and helpers.
// Has no dependencies; every other RTL file but the assert header imports it.
`default_nettype none

package crg_pkg;

	localparam int FIELD_W     = 26;
	localparam int RADIUS_W    = 10;
	localparam int KIND_W      = 3;
	localparam int DEC_W       = 14;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 10;
	localparam int COORD_BITS  = 26;
	localparam int RADIUS_LIMIT = 1023;
	localparam int POINTS_PER_STEP = 8;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int WRAP_SH = (COORD_BITS < FIELD_W) ? FIELD_W - COORD_BITS : 0;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_RADIUS = 2'd1;

	localparam logic                ENABLE_RST     = 1'b1;
	localparam logic [RADIUS_W-1:0] MAX_RADIUS_RST = 10'd256;

	localparam logic signed [DEC_W-1:0] DEC_INIT     = 14'sd2;
	localparam logic signed [DEC_W-1:0] DEC_INC_DIAG = 14'sd10;
	localparam logic signed [DEC_W-1:0] DEC_INC_AXIS = 14'sd6;

	typedef enum logic [KIND_W-1:0] {
		KIND_POINT        = 3'd0,
		KIND_STARTED      = 3'd1,
		KIND_REJ_DISABLED = 3'd2,
		KIND_REJ_SIZE     = 3'd3,
		KIND_IDLE         = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic signed [FIELD_W-1:0]  origin_x;
		logic signed [FIELD_W-1:0]  origin_z;
		logic [RADIUS_W-1:0]        a;
		logic [RADIUS_W-1:0]        b;
		logic                       fin;
	} job_t;

	function automatic logic signed [FIELD_W-1:0] wrap_coord(input logic [FIELD_W-1:0] s);
		logic [FIELD_W-1:0] shifted;
		shifted = s << WRAP_SH;
		return $signed(shifted) >>> WRAP_SH;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/crg_if.sv
// Channel interfaces of the circle rasterizer: request items, result items, register writes.
// Depends on crg_pkg for the field widths.
`default_nettype none

interface crg_req_if import crg_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic signed [FIELD_W-1:0] center_x;
	logic signed [FIELD_W-1:0] center_z;
	logic [RADIUS_W-1:0]       radius;
	logic                      hollow;

	modport source (output valid, opcode, center_x, center_z, radius, hollow, input ready);
	modport sink   (input valid, opcode, center_x, center_z, radius, hollow, output ready);
endinterface

interface crg_rsp_if import crg_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [FIELD_W-1:0] point_x;
	logic signed [FIELD_W-1:0] point_z;
	logic                      last;
	logic                      final_res;

	modport source (output valid, kind, point_x, point_z, last, final_res, input ready);
	modport sink   (input valid, kind, point_x, point_z, last, final_res, output ready);
endinterface

interface crg_cfg_if import crg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/circle_raster_generator_core.sv
// An accepted item passes through the job queue and the back end's job register to the output
// register. A step item that draws points gives eight, one point per cycle while the output
// is not stalled, set by the single output port of the back end; start, rejected and idle items give one.
// The front end accepts a new item every cycle while the job queue has room.
// Reset clears all control state and loads the register defaults; no clearing pass runs.
`default_nettype none

module circle_raster_generator_core import crg_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	crg_req_if.sink   req,
	crg_rsp_if.source rsp,
	crg_cfg_if.sink   cfg
);

	job_t push_job;
	logic push;
	logic push_ready;
	job_t pop_job;
	logic pop;
	logic pop_valid;

	crg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.push_job   (push_job),
		.push       (push),
		.push_ready (push_ready)
	);

	crg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job)
	);

	crg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_job   (pop_job),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

// File: rtl/core/crg_front.sv
// Front end: accepts request items, holds the registers and the circle state, and
// turns each item into one job for the back end. Depends on crg_pkg and crg_if.
`default_nettype none

module crg_front import crg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	crg_req_if.sink   req,
	crg_cfg_if.sink   cfg,
	output job_t      push_job,
	output logic      push,
	input  wire logic push_ready
);

	logic                      enable_q;
	logic [RADIUS_W-1:0]       max_radius_q;
	logic                      active_q;
	logic                      hollow_q;
	logic signed [FIELD_W-1:0] origin_x_q;
	logic signed [FIELD_W-1:0] origin_z_q;
	logic [RADIUS_W-1:0]       step_x_q;
	logic [RADIUS_W-1:0]       edge_y_q;
	logic [RADIUS_W-1:0]       inner_y_q;
	logic signed [DEC_W-1:0]   decision_q;

	logic [RADIUS_W-1:0]       lim;
	logic signed [11:0]        x_cur;
	logic signed [11:0]        y_cur;
	logic signed [11:0]        x_next;
	logic signed [11:0]        y_next;
	logic                      dec_nonneg;
	logic                      col_end;
	logic                      col_done;
	logic signed [DEC_W-1:0]   dec_step;
	logic signed [DEC_W-1:0]   dec_next;
	logic signed [DEC_W-1:0]   dec_start;
	logic                      start_ok;

	assign req.ready = push_ready;
	assign push      = req.valid & push_ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		lim = (32'(max_radius_q) > RADIUS_LIMIT) ? RADIUS_W'(RADIUS_LIMIT) : max_radius_q;
		x_cur = $signed({2'b00, step_x_q});
		y_cur = $signed({2'b00, edge_y_q});
		dec_nonneg = ~decision_q[DEC_W-1];
		col_end = hollow_q | (inner_y_q == edge_y_q);
		x_next = x_cur + 12'sd1;
		y_next = y_cur - $signed({11'b0, dec_nonneg});
		col_done = x_next > y_next;
		dec_step = dec_nonneg ? (DEC_W'(x_cur) - DEC_W'(y_cur)) : DEC_W'(x_cur);
		dec_next = decision_q + (dec_step <<< 2) + (dec_nonneg ? DEC_INC_DIAG : DEC_INC_AXIS);
		dec_start = DEC_INIT - $signed({3'b000, req.radius, 1'b0});
		start_ok = enable_q & (req.radius <= lim);

		push_job.origin_x = origin_x_q;
		push_job.origin_z = origin_z_q;
		push_job.a = step_x_q;
		push_job.b = inner_y_q;
		push_job.fin = 1'b0;
		if (req.opcode == OP_START) begin
			if (!enable_q) begin
				push_job.kind = KIND_REJ_DISABLED;
			end else if (req.radius > lim) begin
				push_job.kind = KIND_REJ_SIZE;
			end else begin
				push_job.kind = KIND_STARTED;
			end
		end else if (!active_q) begin
			push_job.kind = KIND_IDLE;
		end else begin
			push_job.kind = KIND_POINT;
			push_job.fin = col_end & col_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RST;
			max_radius_q <= MAX_RADIUS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_IDX_ENABLE: enable_q <= cfg.data[0];
				CFG_IDX_MAX_RADIUS: max_radius_q <= cfg.data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			hollow_q <= 1'b0;
			origin_x_q <= '0;
			origin_z_q <= '0;
			step_x_q <= '0;
			edge_y_q <= '0;
			inner_y_q <= '0;
			decision_q <= '0;
		end else if (push) begin
			if (req.opcode == OP_START) begin
				if (start_ok) begin
					active_q <= 1'b1;
					hollow_q <= req.hollow;
					origin_x_q <= req.center_x;
					origin_z_q <= req.center_z;
					step_x_q <= '0;
					edge_y_q <= req.radius;
					inner_y_q <= req.hollow ? req.radius : '0;
					decision_q <= dec_start;
				end
			end else if (active_q) begin
				if (col_end) begin
					decision_q <= dec_next;
					edge_y_q <= y_next[RADIUS_W-1:0];
					step_x_q <= x_next[RADIUS_W-1:0];
					inner_y_q <= hollow_q ? y_next[RADIUS_W-1:0] : x_next[RADIUS_W-1:0];
					active_q <= ~col_done;
				end else begin
					inner_y_q <= inner_y_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/crg_queue.sv
// Short job queue between the front and back ends of the circle rasterizer.
// Depends on crg_pkg for the job type.
`default_nettype none

module crg_queue import crg_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      push_ready,
	input  wire logic pop,
	output logic      pop_valid,
	output job_t      pop_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/crg_back.sv
// Back end: takes one job at a time and emits its result items, eight mirrored points
// for a step, through a registered output. Depends on crg_pkg, crg_if and the assert macros.
`default_nettype none
`include "circle_raster_generator_core_assert.svh"

module crg_back import crg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  job_t      q_job,
	output logic      pop,
	crg_rsp_if.source rsp
);

	job_t                      job_q;
	logic                      job_valid_q;
	logic [2:0]                idx_q;
	logic                      out_valid_q;
	kind_t                     kind_q;
	logic signed [FIELD_W-1:0] point_x_q;
	logic signed [FIELD_W-1:0] point_z_q;
	logic                      last_q;
	logic                      final_q;

	logic                      is_pt;
	logic                      job_last;
	logic                      adv;
	logic [RADIUS_W-1:0]       mag_x;
	logic [RADIUS_W-1:0]       mag_z;
	logic [FIELD_W-1:0]        d_x;
	logic [FIELD_W-1:0]        d_z;
	logic signed [FIELD_W-1:0] pt_x;
	logic signed [FIELD_W-1:0] pt_z;

	assign rsp.valid     = out_valid_q;
	assign rsp.kind      = kind_q;
	assign rsp.point_x   = point_x_q;
	assign rsp.point_z   = point_z_q;
	assign rsp.last      = last_q;
	assign rsp.final_res = final_q;

	always_comb begin
		is_pt = (job_q.kind == KIND_POINT);
		job_last = !is_pt || (idx_q == 3'(POINTS_PER_STEP - 1));
		adv = job_valid_q && (!out_valid_q || rsp.ready);
		pop = q_valid && (!job_valid_q || (adv && job_last));
		mag_x = idx_q[2] ? job_q.b : job_q.a;
		mag_z = idx_q[2] ? job_q.a : job_q.b;
		d_x = idx_q[1] ? -FIELD_W'(mag_x) : FIELD_W'(mag_x);
		d_z = (idx_q[1] ^ idx_q[0]) ? -FIELD_W'(mag_z) : FIELD_W'(mag_z);
		pt_x = wrap_coord(job_q.origin_x + d_x);
		pt_z = wrap_coord(job_q.origin_z + d_z);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q <= job_q.kind;
			point_x_q <= is_pt ? pt_x : '0;
			point_z_q <= is_pt ? pt_z : '0;
			last_q <= job_last;
			final_q <= is_pt & job_last & job_q.fin;
		end
		if (pop) begin
			job_q <= q_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			job_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				job_valid_q <= 1'b1;
				idx_q <= '0;
			end else if (adv) begin
				if (job_last) begin
					job_valid_q <= 1'b0;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	`CRG_ASSERT_IMP(a_idx_needs_job, !job_valid_q, idx_q == 3'd0, "point index moved without a job")
	`CRG_ASSERT_IMP(a_status_is_last, out_valid_q && kind_q != KIND_POINT, last_q,
		"status item not marked last")
	`CRG_ASSERT_IMP(a_final_is_last, out_valid_q && final_q, last_q && kind_q == KIND_POINT,
		"final point flag outside the last point of a step")
	`CRG_ASSERT_NXT(a_step_continues, adv && is_pt && !job_last, job_valid_q && idx_q != 3'd0,
		"step job dropped before its eighth point")

endmodule

`default_nettype wire
